// ----- rtl/tocl_pkg.sv -----
package tocl_pkg;

    localparam int DATE_BITS = 48;

    // operation codes
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_QUERY  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_SKIP   = 3'd3;
    localparam logic [2:0] OP_PURGE  = 3'd4;

    // last date a BCD stamp can hold
    localparam logic [DATE_BITS-1:0] END_OF_TIME = 48'h991231235959;

    // sign of a compare
    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_LT = 2'd1,
        CMP_GT = 2'd2
    } cmp_t;

endpackage

// ----- rtl/tocl_ram.sv -----
module tocl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/time_ordered_circular_log.sv -----
// Time-ordered circular record log.
// Input channel (in_valid/in_ready) takes one word: operation, date_stamp,
// until_stamp, payload and skip_amount. Output channel (out_valid/out_ready)
// returns one word per input word: status, result_count, record_date and
// record_payload.
// Records live in two single-port-read memories (date and payload), with a
// registered read port. Append, query and purge each run two binary searches
// (lower and upper bound) over the ring unless it is empty or the key is out
// of range, one memory read per probe and up to log2(depth)+1 probes per
// search. Read next fetches the record at the cursor through the read port;
// skip and unused codes go straight to the result.
// One word is worked on at a time; in_ready is high only while the
// sequencer is idle and the result register is free or being drained.
// When the receiver stalls, the result is held in the output register and
// no new word is taken until it leaves.
// Reset clears the ring pointers, cursor and handshake state; record memory
// contents are left as they are and are only read at written entries.
module time_ordered_circular_log #(
    parameter int LOG_DEPTH    = 64,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      operation,
    input  logic [tocl_pkg::DATE_BITS-1:0]  date_stamp,
    input  logic [tocl_pkg::DATE_BITS-1:0]  until_stamp,
    input  logic [PAYLOAD_BITS-1:0]         payload,
    input  logic [7:0]                      skip_amount,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            status,
    output logic [6:0]                      result_count,
    output logic [tocl_pkg::DATE_BITS-1:0]  record_date,
    output logic [PAYLOAD_BITS-1:0]         record_payload
);

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int DW = tocl_pkg::DATE_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_S_INIT,
        S_S_ADDR,
        S_S_CMP,
        S_RANGE,
        S_WRITE,
        S_RD_WAIT,
        S_RD_DATA,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [2:0]       op_reg;
    logic [DW-1:0]    date_reg;
    logic [DW-1:0]    until_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic             second_reg;      // second (upper-bound) search of a query, purge or append
    logic [DW-1:0]    key_reg;
    logic signed [CW+1:0] lo_reg;
    logic signed [CW+1:0] hi_reg;
    logic [CW-1:0]    mid_reg;
    tocl_pkg::cmp_t   cmp_reg;
    logic [CW-1:0]    is_reg;
    tocl_pkg::cmp_t   cs_reg;
    logic [AW-1:0]    oldest_reg;
    logic [CW-1:0]    count_reg;
    logic [7:0]       cur_pos_reg;
    logic [6:0]       cur_rem_reg;
    logic             out_valid_reg;
    logic             status_reg;
    logic [6:0]       rcount_reg;
    logic [DW-1:0]    rdate_reg;
    logic [PAYLOAD_BITS-1:0] rpay_reg;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [DW-1:0]    rd_date;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    tocl_ram #(.WIDTH(DW), .DEPTH(LOG_DEPTH)) u_date_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (date_reg),
        .raddr (raddr),
        .rdata (rd_date)
    );

    tocl_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(LOG_DEPTH)) u_pay_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (pay_reg),
        .raddr (raddr),
        .rdata (rd_pay)
    );

    // map a logical index to its physical slot
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] oldest,
                                               input logic [7:0] idx);
        logic [8:0] room;
        logic [8:0] r;
        begin
            room = 9'(LOG_DEPTH) - 9'(oldest);
            if (room > 9'(idx))
                r = 9'(oldest) + 9'(idx);
            else
                r = 9'(idx) - room;
            if (r >= 9'(LOG_DEPTH))
                r = '0;
            return r[AW-1:0];
        end
    endfunction

    // search probe index and compare of key against the returned date
    logic signed [CW+1:0] mid_calc;
    tocl_pkg::cmp_t       cmp_now;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >>> 1);
    always_comb
    begin
        if (key_reg < rd_date)
            cmp_now = tocl_pkg::CMP_LT;
        else if (key_reg > rd_date)
            cmp_now = tocl_pkg::CMP_GT;
        else
            cmp_now = tocl_pkg::CMP_EQ;
    end

    // range finish: adjust ends, count matches
    logic              rng_empty;
    logic [CW-1:0]     is_adj;
    logic [CW-1:0]     iu_adj;
    logic [CW-1:0]     rng_n;
    always_comb
    begin
        is_adj = is_reg;
        iu_adj = mid_reg;
        if (cs_reg == tocl_pkg::CMP_GT && is_reg < count_reg - 1'b1)
            is_adj = is_reg + 1'b1;
        if (cmp_reg == tocl_pkg::CMP_LT && mid_reg != '0)
            iu_adj = mid_reg - 1'b1;
        rng_empty = (is_reg == mid_reg)
                    && ((cs_reg == tocl_pkg::CMP_LT) == (cmp_reg == tocl_pkg::CMP_LT))
                    && cs_reg != tocl_pkg::CMP_EQ && cmp_reg != tocl_pkg::CMP_EQ;
        if (rng_empty || iu_adj < is_adj)
            rng_n = '0;
        else
            rng_n = iu_adj - is_adj + 1'b1;
    end

    // append slot
    logic          full;
    logic [AW-1:0] app_slot;
    assign full     = count_reg >= CW'(LOG_DEPTH);
    assign app_slot = full ? oldest_reg : slot_of(oldest_reg, 8'(count_reg));

    // issue the probe read while the probe index is being registered
    assign we    = (state_reg == S_WRITE);
    assign waddr = app_slot;
    assign raddr = (state_reg == S_RD_WAIT) ? slot_of(oldest_reg, cur_pos_reg)
                 : (state_reg == S_S_ADDR)  ? slot_of(oldest_reg, 8'(mid_calc[CW-1:0]))
                 : slot_of(oldest_reg, 8'(mid_reg));

    assign in_ready       = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_count   = rcount_reg;
    assign record_date    = rdate_reg;
    assign record_payload = rpay_reg;

    // sequencer and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            cur_pos_reg   <= '0;
            cur_rem_reg   <= '0;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg     <= operation;
                        date_reg   <= date_stamp;
                        until_reg  <= until_stamp;
                        pay_reg    <= payload;
                        second_reg <= 1'b0;
                        rdate_reg  <= '0;
                        rpay_reg   <= '0;
                        unique case (operation)
                            tocl_pkg::OP_APPEND, tocl_pkg::OP_PURGE:
                            begin
                                status_reg <= 1'b0;
                                rcount_reg <= '0;
                                key_reg    <= date_stamp;
                                if (count_reg == '0 || date_stamp > tocl_pkg::END_OF_TIME)
                                    state_reg <= (operation == tocl_pkg::OP_APPEND)
                                                 ? S_WRITE : S_DONE;
                                else
                                    state_reg <= S_S_INIT;
                            end
                            tocl_pkg::OP_QUERY:
                            begin
                                status_reg <= 1'b0;
                                rcount_reg <= '0;
                                key_reg    <= date_stamp;
                                if (count_reg == '0 || date_stamp > until_stamp)
                                begin
                                    cur_rem_reg <= '0;
                                    state_reg   <= S_DONE;
                                end
                                else
                                    state_reg <= S_S_INIT;
                            end
                            tocl_pkg::OP_READ:
                            begin
                                if (cur_rem_reg != '0 && 9'(cur_pos_reg) < 9'(count_reg))
                                begin
                                    status_reg <= 1'b0;
                                    rcount_reg <= '0;
                                    state_reg  <= S_RD_WAIT;
                                end
                                else
                                begin
                                    status_reg <= 1'b1;
                                    rcount_reg <= cur_rem_reg;
                                    state_reg  <= S_DONE;
                                end
                            end
                            tocl_pkg::OP_SKIP:
                            begin
                                status_reg <= 1'b0;
                                if (8'(cur_rem_reg) > skip_amount)
                                begin
                                    cur_pos_reg <= cur_pos_reg - skip_amount;
                                    cur_rem_reg <= cur_rem_reg - 7'(skip_amount);
                                    rcount_reg  <= cur_rem_reg - 7'(skip_amount);
                                end
                                else
                                begin
                                    cur_rem_reg <= '0;
                                    rcount_reg  <= '0;
                                end
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                status_reg <= 1'b0;
                                rcount_reg <= '0;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_S_INIT:
                begin
                    lo_reg    <= '0;
                    hi_reg    <= (CW+2)'($signed({2'b00, count_reg}) - 1);
                    mid_reg   <= '0;
                    cmp_reg   <= tocl_pkg::CMP_EQ;
                    state_reg <= S_S_ADDR;
                end
                S_S_ADDR:
                begin
                    // probe or finish
                    if (hi_reg >= lo_reg)
                    begin
                        mid_reg   <= mid_calc[CW-1:0];
                        state_reg <= S_S_CMP;
                    end
                    else
                        state_reg <= S_RANGE;
                end
                S_S_CMP:
                begin
                    cmp_reg <= cmp_now;
                    unique case (cmp_now)
                        tocl_pkg::CMP_LT:
                        begin
                            hi_reg    <= (CW+2)'($signed({2'b00, mid_reg}) - 1);
                            state_reg <= S_S_ADDR;
                        end
                        tocl_pkg::CMP_GT:
                        begin
                            lo_reg    <= (CW+2)'($signed({2'b00, mid_reg}) + 1);
                            state_reg <= S_S_ADDR;
                        end
                        default:
                            state_reg <= S_RANGE;
                    endcase
                end
                S_RANGE:
                begin
                    if (!second_reg)
                    begin
                        // first search done, run the upper bound
                        is_reg     <= mid_reg;
                        cs_reg     <= cmp_reg;
                        second_reg <= 1'b1;
                        key_reg    <= (op_reg == tocl_pkg::OP_QUERY)
                                      ? until_reg : tocl_pkg::END_OF_TIME;
                        state_reg  <= S_S_INIT;
                    end
                    else if (op_reg == tocl_pkg::OP_QUERY)
                    begin
                        if (rng_n != '0)
                            cur_pos_reg <= 8'(iu_adj);
                        cur_rem_reg <= 7'(rng_n);
                        rcount_reg  <= 7'(rng_n);
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        // purge tail
                        count_reg  <= count_reg - rng_n;
                        rcount_reg <= 7'(rng_n);
                        state_reg  <= (op_reg == tocl_pkg::OP_APPEND) ? S_WRITE : S_DONE;
                    end
                end
                S_WRITE:
                begin
                    if (full)
                        oldest_reg <= (32'(oldest_reg) + 1 >= LOG_DEPTH)
                                      ? '0 : oldest_reg + 1'b1;
                    else
                        count_reg <= count_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_RD_WAIT:
                    state_reg <= S_RD_DATA;
                S_RD_DATA:
                begin
                    rdate_reg   <= rd_date;
                    rpay_reg    <= rd_pay;
                    cur_pos_reg <= cur_pos_reg - 1'b1;
                    cur_rem_reg <= cur_rem_reg - 1'b1;
                    rcount_reg  <= cur_rem_reg - 1'b1;
                    state_reg   <= S_DONE;
                end
                S_DONE:
                begin
                    // wait for the result register to free up
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
